/* src/lkv_pkg.sv */
// shared constants and types for the lru key-value cache
package lkv_pkg;

	localparam int CAPACITY_MAX_DEF = 16;
	localparam int KEY_W = 32;
	localparam int VALUE_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
	localparam logic [VALUE_W-1:0] MISS_VALUE = '1;
	localparam logic [VALUE_W-1:0] SET_VALUE = '0;
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_SET = 1'b1;

	typedef struct packed {
		logic commit;
		logic hit;
		logic set;
		logic full;
	} lkv_cmd_t;

endpackage

/* src/lkv_cell.sv */
// one recency-ordered entry of the cache, shifts from its more recent neighbor
module lkv_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkv_pkg::lkv_cmd_t           cmd,
	input  logic                        lookup,
	input  logic [lkv_pkg::KEY_W-1:0]   lookup_key,
	input  logic [lkv_pkg::KEY_W-1:0]   prev_key,
	input  logic [lkv_pkg::VALUE_W-1:0] prev_value,
	input  logic                        prev_valid,
	input  logic                        tail_match,
	input  logic [lkv_pkg::VALUE_W-1:0] tail_sel,
	output logic [lkv_pkg::KEY_W-1:0]   entry_key,
	output logic [lkv_pkg::VALUE_W-1:0] entry_value,
	output logic                        entry_valid,
	output logic                        chain_match,
	output logic [lkv_pkg::VALUE_W-1:0] chain_sel
);
	import lkv_pkg::*;

	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic               valid_q;
	logic               match_q;
	logic               load;

	assign chain_match = tail_match | match_q;
	assign chain_sel   = tail_sel | (match_q ? value_q : '0);

	// hit: every entry at or above the match moves down one place
	// miss on set: the valid run moves down, the last one drops off when full
	assign load = cmd.commit & (cmd.hit ? chain_match
		: (cmd.set & (cmd.full ? valid_q : prev_valid)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (lookup) begin
				match_q <= valid_q && (key_q == lookup_key);
			end
			if (load) begin
				valid_q <= prev_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q   <= prev_key;
			value_q <= prev_value;
		end
	end

	assign entry_key   = key_q;
	assign entry_value = value_q;
	assign entry_valid = valid_q;

endmodule

/* src/lru_key_value_cache.sv */
// top level of the lru key-value cache: control, head entry and the row of cells
//
// channel   direction  handshake            payload
// in        receive    in_valid / in_stall  func, key, value
// out       send       out_valid / out_stall hit, read_value, evicted
// cfg       receive    cfg_write            cfg_data (capacity)
//
// per transaction: the key is compared in every cell at accept; at commit, in
// the match state, the row shifts and the result is registered
// a waiting result holds the shift back while out_stall is high; no new
// transaction is accepted until the shift is done
// reset clears valid bits, occupancy, state and output valid; keys and values
// are kept; capacity resets to 16
module lru_key_value_cache #(
	parameter int CAPACITY_MAX = lkv_pkg::CAPACITY_MAX_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [lkv_pkg::KEY_W-1:0]   key,
	input  logic [lkv_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [lkv_pkg::VALUE_W-1:0] read_value,
	output logic                        evicted,
	input  logic                        cfg_write,
	input  logic [lkv_pkg::CAP_W-1:0]   cfg_data
);
	import lkv_pkg::*;

	localparam int CW = $clog2(CAPACITY_MAX + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;
	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_MATCH = 1'b1;

	logic                state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       occ_q;
	logic                func_q;
	logic [KEY_W-1:0]    key_q;
	logic [VALUE_W-1:0]  value_q;
	logic                out_valid_q;
	logic                hit_q;
	logic [VALUE_W-1:0]  read_value_q;
	logic                evicted_q;

	logic                accept;
	logic                commit;
	logic [EW-1:0]       eff_cap;
	logic                full;
	logic                hit_d;
	lkv_cmd_t            cmd;

	logic [KEY_W-1:0]    link_key   [CAPACITY_MAX+1];
	logic [VALUE_W-1:0]  link_value [CAPACITY_MAX+1];
	logic                link_valid [CAPACITY_MAX+1];
	logic                tail_match [CAPACITY_MAX+1];
	logic [VALUE_W-1:0]  tail_sel   [CAPACITY_MAX+1];
	logic [CAPACITY_MAX-1:0] valid_vec;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q == ST_MATCH);
	assign commit   = (state_q == ST_MATCH) && (!out_valid_q || !out_stall);

	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(CAPACITY_MAX)) begin
			eff_cap = EW'(CAPACITY_MAX);
		end else begin
			eff_cap = EW'(cap_q);
		end
	end

	assign full  = (EW'(occ_q) >= eff_cap) && (occ_q != '0);
	assign hit_d = tail_match[0];

	assign cmd.commit = commit;
	assign cmd.hit    = hit_d;
	assign cmd.set    = (func_q == FUNC_SET);
	assign cmd.full   = full;

	// head of the row: the transaction's own entry becomes most recent
	assign link_key[0]   = key_q;
	assign link_value[0] = (func_q == FUNC_SET) ? value_q : tail_sel[0];
	assign link_valid[0] = 1'b1;
	assign tail_match[CAPACITY_MAX] = 1'b0;
	assign tail_sel[CAPACITY_MAX]   = '0;

	for (genvar i = 0; i < CAPACITY_MAX; i++) begin : g_cell
		lkv_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.lookup      (accept),
			.lookup_key  (key),
			.prev_key    (link_key[i]),
			.prev_value  (link_value[i]),
			.prev_valid  (link_valid[i]),
			.tail_match  (tail_match[i+1]),
			.tail_sel    (tail_sel[i+1]),
			.entry_key   (link_key[i+1]),
			.entry_value (link_value[i+1]),
			.entry_valid (link_valid[i+1]),
			.chain_match (tail_match[i]),
			.chain_sel   (tail_sel[i])
		);
		assign valid_vec[i] = link_valid[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAPACITY_RESET;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				cap_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit && (func_q == FUNC_SET) && !hit_d && !full) begin
				occ_q <= occ_q + CW'(1);
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			key_q   <= key;
			value_q <= value;
		end
		if (commit) begin
			hit_q     <= hit_d;
			evicted_q <= (func_q == FUNC_SET) && !hit_d && full;
			if (func_q == FUNC_SET) begin
				read_value_q <= SET_VALUE;
			end else if (hit_d) begin
				read_value_q <= tail_sel[0];
			end else begin
				read_value_q <= MISS_VALUE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	// valid entries always form a run from the most recent cell
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + CAPACITY_MAX'(1))) == '0)
		else $error("valid entries not contiguous");

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(occ_q))
		else $error("occupancy does not match valid entries");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid && (state_q == ST_IDLE))
		else $error("commit did not present a result");

	a_get_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && (func_q == FUNC_GET) && !hit_d) |=> (read_value == MISS_VALUE) && !evicted)
		else $error("get miss result wrong");

endmodule

/* tb/sv/lkv_result_checker.sv */
// checker for the lru key-value cache: predicts each result and compares it
`timescale 1ns / 100ps

module lkv_result_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        func,
	input  logic [lkv_pkg::KEY_W-1:0]   key,
	input  logic [lkv_pkg::VALUE_W-1:0] value,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        hit,
	input  logic [lkv_pkg::VALUE_W-1:0] read_value,
	input  logic                        evicted,
	input  logic                        cfg_write,
	input  logic [lkv_pkg::CAP_W-1:0]   cfg_data,
	output int                          fail_count,
	output int                          outstanding
);

	localparam int SLOTS = lkv_pkg::CAPACITY_MAX_DEF;

	typedef struct packed {
		logic                        hit;
		logic [lkv_pkg::VALUE_W-1:0] read_value;
		logic                        evicted;
	} lkv_result_t;

	logic [lkv_pkg::CAP_W-1:0]   capacity;
	logic [lkv_pkg::KEY_W-1:0]   slot_key [SLOTS];
	logic [lkv_pkg::VALUE_W-1:0] slot_value [SLOTS];
	logic                        slot_valid [SLOTS];
	int unsigned                 recency [SLOTS];
	int unsigned                 occupancy;
	lkv_result_t                 pending_results [$];

	// make slot s most recent, aging every valid slot that was more recent
	function automatic void promote(input int s);
		int unsigned old_rank;
		old_rank = recency[s];
		for (int i = 0; i < SLOTS; i++)
			if (slot_valid[i] && i != s && recency[i] < old_rank)
				recency[i]++;
		recency[s] = 0;
	endfunction

	function automatic lkv_result_t cache_access(input logic op,
			input logic [lkv_pkg::KEY_W-1:0] k, input logic [lkv_pkg::VALUE_W-1:0] v);
		lkv_result_t r;
		int slot;
		int victim;
		int unsigned cap_eff;
		slot = -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot < 0 && slot_valid[i] && slot_key[i] == k)
				slot = i;
		r.hit = (slot >= 0);
		r.read_value = lkv_pkg::SET_VALUE;
		r.evicted = 1'b0;
		if (capacity == 0)
			cap_eff = 1;
		else if (int'(capacity) > SLOTS)
			cap_eff = SLOTS;
		else
			cap_eff = 32'(capacity);
		if (op == lkv_pkg::FUNC_GET) begin
			if (slot >= 0) begin
				r.read_value = slot_value[slot];
				promote(slot);
			end else begin
				r.read_value = lkv_pkg::MISS_VALUE;
			end
		end else if (slot >= 0) begin
			slot_value[slot] = v;
			promote(slot);
		end else if (occupancy >= cap_eff && occupancy > 0) begin
			victim = -1;
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i] && (victim < 0 || recency[i] > recency[victim]))
					victim = i;
			slot_key[victim] = k;
			slot_value[victim] = v;
			promote(victim);
			r.evicted = 1'b1;
		end else begin
			victim = -1;
			for (int i = SLOTS - 1; i >= 0; i--)
				if (!slot_valid[i])
					victim = i;
			for (int i = 0; i < SLOTS; i++)
				if (slot_valid[i])
					recency[i]++;
			slot_key[victim] = k;
			slot_value[victim] = v;
			slot_valid[victim] = 1'b1;
			recency[victim] = 0;
			occupancy++;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		lkv_result_t want;
		if (!arst_n) begin
			capacity = lkv_pkg::CAPACITY_RESET;
			for (int i = 0; i < SLOTS; i++) begin
				slot_valid[i] = 1'b0;
				recency[i] = 0;
			end
			occupancy = 0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no transaction pending: hit %0d read_value %0d evicted %0d",
						hit, $signed(read_value), evicted);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						fail_count++;
					end
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d",
							$signed(want.read_value), $signed(read_value));
						fail_count++;
					end
					if (evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, evicted);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(cache_access(func, key, value));
			if (cfg_write)
				capacity = cfg_data;
			outstanding = pending_results.size();
		end
	end

endmodule

/* tb/sv/lru_key_value_cache_test.sv */
// top of the lru key-value cache testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module lru_key_value_cache_test;

	localparam int RANDOM_ITEMS = 1680;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 400;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic                        func;
	logic [lkv_pkg::KEY_W-1:0]   key;
	logic [lkv_pkg::VALUE_W-1:0] value;
	logic                        out_valid;
	logic                        out_stall;
	logic                        hit;
	logic [lkv_pkg::VALUE_W-1:0] read_value;
	logic                        evicted;
	logic                        cfg_write;
	logic [lkv_pkg::CAP_W-1:0]   cfg_data;
	int                          fail_count;
	int                          outstanding;
	int                          cycle_count = 0;
	logic                        calm = 1'b0;
	logic                        hold_wanted = 1'b0;

	lru_key_value_cache DUT (.*);

	lkv_result_checker cache_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	// receiver side: random stall runs, and one long hold-off
	initial begin
		int run;
		logic stalling;
		logic hold_done;
		run = 0;
		stalling = 1'b0;
		hold_done = 1'b0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_wanted && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				run = 0;
				stalling = 1'b0;
			end else begin
				if (run == 0) begin
					if (stalling) begin
						stalling = 1'b0;
						run = $urandom_range(1, 6);
					end else begin
						run = idle_len();
						stalling = (run > 0);
						if (!stalling)
							run = $urandom_range(1, 6);
					end
				end
				run--;
				out_stall <= stalling;
			end
		end
	end

	task automatic send_op(input logic op, input logic [lkv_pkg::KEY_W-1:0] k,
			input logic [lkv_pkg::VALUE_W-1:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// wait until every transaction has its result and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		wait (outstanding == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] c);
		settle();
		cfg_write <= 1'b1;
		cfg_data <= c;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [lkv_pkg::KEY_W-1:0] key_pool [24];
		logic [lkv_pkg::KEY_W-1:0] k;
		logic [lkv_pkg::CAP_W-1:0] cap;
		int pool_n;
		int done_items;
		int phase;
		int phase_len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = lkv_pkg::FUNC_GET;
		key = '0;
		value = '0;
		cfg_write = 1'b0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, update and miss at reset capacity
		send_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_op(lkv_pkg::FUNC_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_op(lkv_pkg::FUNC_SET, 32'h0000_0000, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_op(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_op(lkv_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_SET, 32'hFFFF_FFFF, 32'h1234_5678);
		send_op(lkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_GET, 32'h0000_0001, 32'h0000_0000);
		// capacity below occupancy: each new key evicts one
		write_capacity(5'd1);
		send_op(lkv_pkg::FUNC_SET, 32'h0000_0005, 32'h0000_0055);
		send_op(lkv_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
		send_op(lkv_pkg::FUNC_SET, 32'h0000_0006, 32'h0000_0066);
		send_op(lkv_pkg::FUNC_GET, 32'h0000_0005, 32'h0000_0000);
		// zero capacity acts as one
		write_capacity(5'd0);
		send_op(lkv_pkg::FUNC_SET, 32'h0000_0007, 32'hA5A5_A5A5);
		send_op(lkv_pkg::FUNC_GET, 32'h0000_0007, 32'h0000_0000);
		// capacity above the maximum saturates
		write_capacity(5'd31);
		for (int i = 0; i < 4; i++)
			send_op(lkv_pkg::FUNC_SET, 32'h4000_0000 + i, $urandom);
		send_op(lkv_pkg::FUNC_GET, 32'h4000_0002, 32'h0000_0000);

		done_items = 0;
		phase = 0;
		while (done_items < RANDOM_ITEMS) begin
			case (phase)
				0: cap = 5'd16;
				1: cap = 5'd3;
				2: cap = 5'd1;
				3: cap = 5'd0;
				4: cap = 5'd31;
				5: cap = 5'd8;
				default: cap = 5'($urandom_range(0, 31));
			endcase
			write_capacity(cap);
			pool_n = $urandom_range(1, 24);
			for (int i = 0; i < 24; i++) begin
				key_pool[i] = $urandom;
				case ($urandom_range(0, 15))
					0: key_pool[i] = 32'h8000_0000;
					1: key_pool[i] = 32'h7FFF_FFFF;
					2: key_pool[i] = 32'hFFFF_FFFF;
					3: key_pool[i] = 32'h0000_0000;
					default: ;
				endcase
			end
			phase_len = $urandom_range(80, 240);
			if (phase_len > RANDOM_ITEMS - done_items)
				phase_len = RANDOM_ITEMS - done_items;
			for (int n = 0; n < phase_len; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 4) == 0);
				if (phase == 1 && n == 20)
					hold_wanted = 1'b1;
				if ($urandom_range(0, 9) == 0)
					k = $urandom;
				else
					k = key_pool[$urandom_range(0, pool_n - 1)];
				send_op($urandom_range(0, 1) ? lkv_pkg::FUNC_SET : lkv_pkg::FUNC_GET,
					k, $urandom);
			end
			done_items += phase_len;
			phase++;
		end

		settle();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
